// ----- rtl/nat16_pkg.sv -----
// Shared types and codes for the 16-bit ALU with funnel shifts and divider.
// No dependencies.
package nat16_pkg;

  localparam int unsigned WordBits = 16;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrBits = 2;
  localparam int unsigned DivLat = 16;

  localparam logic [3:0] K_AND = 4'd0;
  localparam logic [3:0] K_OR  = 4'd1;
  localparam logic [3:0] K_NOT = 4'd2;
  localparam logic [3:0] K_NEG = 4'd3;
  localparam logic [3:0] K_CMP = 4'd4;
  localparam logic [3:0] K_ADD = 4'd5;
  localparam logic [3:0] K_SUB = 4'd6;
  localparam logic [3:0] K_INC = 4'd7;
  localparam logic [3:0] K_MUL = 4'd8;
  localparam logic [3:0] K_DIV = 4'd9;
  localparam logic [3:0] K_MOD = 4'd10;
  localparam logic [3:0] K_SHL = 4'd11;
  localparam logic [3:0] K_SHR = 4'd12;
  localparam logic [3:0] K_ASR = 4'd13;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CARRY     = 3'd1;
  localparam logic [2:0] ST_BORROW    = 3'd2;
  localparam logic [2:0] ST_DIV_ZERO  = 3'd3;
  localparam logic [2:0] ST_MOD_ZERO  = 3'd4;
  localparam logic [2:0] ST_SHIFT_BIG = 3'd5;
  localparam logic [2:0] ST_ONE_WORD  = 3'd6;
  localparam logic [2:0] ST_TWO_WORD  = 3'd7;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [4:0]  shift_amount;
    logic [15:0] spill_in;
    logic [15:0] fill_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_low;
    logic [15:0] result_high;
    logic [15:0] fill_out;
    logic [2:0]  status;
    logic [1:0]  order;
    logic        a_is_zero;
  } out_item_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic      is_div;   // needs the divider
    out_item_t quick;    // full result for non-divide kinds, flags for divide
    logic [15:0] dividend;
    logic [15:0] divisor;
    logic        want_rem_low; // mod puts remainder in result_low
  } task_t;

endpackage

// ----- rtl/nat16_front.sv -----
// Front end: accepts requests, computes the non-divide kinds, classifies divides.
// Depends on nat16_pkg.
module nat16_front import nat16_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_item_t req,
  output logic     task_vld_r,
  output task_t    task_r
);

  task_t    task_nxt;
  logic [16:0] sum;
  logic [15:0] fsrc;
  logic [15:0] sh_lo, sh_hi, sh_fo;
  logic [4:0]  comp;
  logic [31:0] prod;
  logic        bz;

  always_comb begin
    out_item_t o;
    o = '0;
    o.order = (req.operand_a < req.operand_b) ? ORD_LT :
              ((req.operand_a == req.operand_b) ? ORD_EQ : ORD_GT);
    o.a_is_zero = (req.operand_a == 16'd0);
    sum = 17'd0;
    prod = req.operand_a * req.operand_b;
    bz = (req.operand_b == 16'd0);
    comp = 5'd16 - req.shift_amount;
    fsrc = (req.kind == K_ASR) ? {16{req.operand_a[15]}} : req.fill_in;
    sh_lo = 16'd0; sh_hi = 16'd0; sh_fo = 16'd0;
    if (req.kind == K_SHL) begin
      sh_fo = (comp[4]) ? 16'd0 : (req.fill_in >> comp[3:0]);
      sh_lo = (req.operand_a << req.shift_amount[3:0]) | sh_fo;
      sh_hi = (req.spill_in << req.shift_amount[3:0]) |
              ((comp[4]) ? 16'd0 : (req.operand_a >> comp[3:0]));
    end else begin
      sh_fo = (comp[4]) ? 16'd0 : (fsrc << comp[3:0]);
      sh_lo = (req.operand_a >> req.shift_amount[3:0]) | sh_fo;
      sh_hi = (req.spill_in >> req.shift_amount[3:0]) |
              ((comp[4]) ? 16'd0 : (req.operand_a << comp[3:0]));
    end
    task_nxt = '0;
    task_nxt.dividend = req.operand_a;
    task_nxt.divisor = req.operand_b;
    task_nxt.want_rem_low = (req.kind == K_MOD);
    case (req.kind)
      K_AND: o.result_low = req.operand_a & req.operand_b;
      K_OR:  o.result_low = req.operand_a | req.operand_b;
      K_NOT: o.result_low = ~req.operand_a;
      K_NEG: o.result_low = ~req.operand_a + 16'd1;
      K_CMP: o.result_low = 16'd0;
      K_ADD: begin
        sum = {1'b0, req.operand_a} + {1'b0, req.operand_b};
        o.result_low = sum[15:0];
        o.status = sum[16] ? ST_CARRY : ST_OK;
      end
      K_SUB: begin
        o.result_low = req.operand_a - req.operand_b;
        o.status = (req.operand_b > req.operand_a) ? ST_BORROW : ST_OK;
      end
      K_INC: begin
        o.result_low = req.operand_a + 16'd1;
        o.status = (req.operand_a == 16'hFFFF) ? ST_CARRY : ST_OK;
      end
      K_MUL: begin
        o.result_low = prod[15:0];
        o.result_high = prod[31:16];
        o.status = (prod[31:16] == 16'd0) ? ST_ONE_WORD : ST_TWO_WORD;
      end
      K_DIV: begin
        o.status = bz ? ST_DIV_ZERO : ST_OK;
        task_nxt.is_div = !bz;
      end
      K_MOD: begin
        o.status = bz ? ST_MOD_ZERO : ST_OK;
        task_nxt.is_div = !bz;
      end
      K_SHL, K_SHR, K_ASR: begin
        if (req.shift_amount[4]) begin
          o.status = ST_SHIFT_BIG;
          o.result_low = req.operand_a;
          o.result_high = req.spill_in;
          o.fill_out = req.fill_in;
        end else begin
          o.result_low = sh_lo;
          o.result_high = sh_hi;
          o.fill_out = sh_fo;
        end
      end
      default: o = o;
    endcase
    task_nxt.quick = o;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_vld_r <= 1'b0;
    end else begin
      task_vld_r <= take;
    end
    task_r <= task_nxt;
  end

endmodule

// ----- rtl/nat16_queue.sv -----
// Short FIFO between front and back end; reports its fill count for the busy logic.
// Depends on nat16_pkg.
module nat16_queue import nat16_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  task_t push_data,
  input  logic  pop,
  output logic  not_empty,
  output task_t head,
  output logic [QPtrBits:0] count_r
);

  task_t mem_r [QDepth];
  logic [QPtrBits-1:0] wp_r, rp_r;

  assign not_empty = (count_r != '0);
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      count_r <= count_r + {{QPtrBits{1'b0}}, push} - {{QPtrBits{1'b0}}, pop};
    end
    if (push) mem_r[wp_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && count_r == QDepth[QPtrBits:0]))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && count_r == '0))
    else $error("queue underflow");

endmodule

// ----- rtl/nat16_back.sv -----
// Back end: pipelined restoring divider, one quotient bit per stage, plus
// in-order result delivery. Depends on nat16_pkg.
module nat16_back import nat16_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_vld,
  input  task_t     q_head,
  output logic      q_pop,
  output logic      out_strobe,
  output out_item_t out_item
);

  // Each stage carries the whole task; divide tasks iterate through all stages.
  logic        vld_r [DivLat+1];
  task_t       tk_r  [DivLat+1];
  logic [15:0] rem_r [DivLat+1];
  logic [15:0] quo_r [DivLat+1];

  assign q_pop = q_vld;

  always_comb begin
    out_item = tk_r[DivLat].quick;
    if (tk_r[DivLat].is_div) begin
      if (tk_r[DivLat].want_rem_low) begin
        out_item.result_low = rem_r[DivLat];
      end else begin
        out_item.result_low = quo_r[DivLat];
        out_item.result_high = rem_r[DivLat];
      end
    end
  end
  assign out_strobe = vld_r[DivLat];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DivLat; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= q_vld;
      for (int i = 1; i <= DivLat; i++) vld_r[i] <= vld_r[i-1];
    end
    tk_r[0] <= q_head;
    rem_r[0] <= 16'd0;
    quo_r[0] <= q_head.dividend;
    for (int i = 1; i <= DivLat; i++) begin
      logic [16:0] trial;
      trial = {rem_r[i-1], quo_r[i-1][15]} - {1'b0, tk_r[i-1].divisor};
      tk_r[i] <= tk_r[i-1];
      if (!trial[16]) begin
        rem_r[i] <= trial[15:0];
        quo_r[i] <= {quo_r[i-1][14:0], 1'b1};
      end else begin
        rem_r[i] <= {rem_r[i-1][14:0], quo_r[i-1][15]};
        quo_r[i] <= {quo_r[i-1][14:0], 1'b0};
      end
    end
  end

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && tk_r[DivLat].is_div) |-> (rem_r[DivLat] < tk_r[DivLat].divisor))
    else $error("remainder too big");

endmodule

// ----- rtl/nat16_alu_funnel_shift_divide.sv -----
// Top level of the 16-bit unsigned ALU with funnel shifts and divider.
// Depends on nat16_pkg, nat16_front, nat16_queue, nat16_back.
//
//  channel  handshake            payload
//  in       start / busy         in_item   (in_item_t)
//  out      out_strobe (1 cycle) out_item  (out_item_t)
//
// One request per cycle while busy is low. Each result passes, in order, the front
// register, loaded at the edge that accepts its request, then a queue slot, the
// divider load stage and 16 divider stages before it is on the out ports.
// Every request passes through the divider pipeline to keep order.
// Reset clears all valid flags and queue pointers. The receiver cannot stall,
// so busy stays low after reset.
module nat16_alu_funnel_shift_divide import nat16_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  logic  task_vld;
  task_t task_q;
  logic  q_ne, q_pop;
  task_t q_head;
  logic [QPtrBits:0] q_cnt;

  // hold requests only if the queue could not absorb the front register
  assign busy = (q_cnt >= QDepth[QPtrBits:0] - 1'b1) && !q_pop;

  nat16_front u_front (
    .clk, .rst_n, .take(start && !busy), .req(in_item),
    .task_vld_r(task_vld), .task_r(task_q)
  );

  nat16_queue u_queue (
    .clk, .rst_n, .push(task_vld), .push_data(task_q), .pop(q_pop),
    .not_empty(q_ne), .head(q_head), .count_r(q_cnt)
  );

  nat16_back u_back (
    .clk, .rst_n, .q_vld(q_ne), .q_head, .q_pop,
    .out_strobe, .out_item
  );

endmodule
